/* hdl/pio_pkg.sv */
// Package: shared types and constants of the parallel I/O controller.
`default_nettype none
package pio_pkg;

    typedef enum logic [2:0] {
        ACT_WRITE = 3'd0,
        ACT_READ  = 3'd1,
        ACT_STB   = 3'd2,
        ACT_POLL  = 3'd3,
        ACT_ACK   = 3'd4,
        ACT_RETI  = 3'd5,
        ACT_NOP6  = 3'd6,
        ACT_NOP7  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        MODE_OUT  = 2'd0,
        MODE_IN   = 2'd1,
        MODE_BIDI = 2'd2,
        MODE_BIT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_NORMAL = 2'd0,
        SEQ_DIR    = 2'd1,
        SEQ_MASK   = 2'd2,
        SEQ_RSVD   = 2'd3
    } seq_t;

    localparam logic [3:0] CW_ICTL_ONLY = 4'h3;
    localparam logic [3:0] CW_ICTL      = 4'h7;
    localparam logic [3:0] CW_MODE      = 4'hf;

    typedef struct packed {
        logic [2:0] action;
        logic       port_select;
        logic       is_control;
        logic [7:0] write_data;
        logic       strobe_level;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
    } pio_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
        logic       ready_a;
        logic       ready_b;
        logic [1:0] ready_pulse;
        logic       int_line;
    } pio_out_t;

endpackage
`default_nettype wire

/* hdl/pio_if.sv */
// Interface: valid/ready channel carrying one payload struct.
`default_nettype none
interface pio_in_if;
    logic            valid;
    logic            ready;
    pio_pkg::pio_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pio_out_if;
    logic             valid;
    logic             ready;
    pio_pkg::pio_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/parallel_io_controller.sv */
// Top level: two-port parallel I/O controller with daisy-chained interrupts.
// An accepted result is registered in the output register, which refills while taken.
// Throughput: one transaction per cycle, except while the output register is stalled.
// in.ready is high whenever the output register is empty or being taken.
// rst_n (asynchronous, active low) returns all ports to input mode, masks
// cleared to all-ones, interrupts idle, and the output register empty.
`default_nettype none
module parallel_io_controller (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    pio_in_if.sink         in_ch,
    pio_out_if.source      out_ch
);

    logic        cfg_reg;
    logic [1:0]  seq_reg [2];
    logic [1:0]  mode_reg [2];
    logic [1:0]  ien_reg, pend_reg, req_reg, svc_reg, stb_reg, match_reg;
    logic [7:0]  icw_reg [2];
    logic [7:0]  inl_reg [2];
    logic [7:0]  outl_reg [2];
    logic [7:0]  vec_reg [2];
    logic [7:0]  mask_reg [2];
    logic [7:0]  dir_reg [2];
    logic [7:0]  drv_reg [2];
    logic [1:0]  rdy_reg;
    logic [2:0]  def_reg;
    logic        ovalid_reg;
    pio_pkg::pio_out_t opay_reg;

    logic [1:0]  seq_next [2];
    logic [1:0]  mode_next [2];
    logic [1:0]  ien_next, pend_next, req_next, svc_next, stb_next, match_next;
    logic [7:0]  icw_next [2];
    logic [7:0]  inl_next [2];
    logic [7:0]  outl_next [2];
    logic [7:0]  vec_next [2];
    logic [7:0]  mask_next [2];
    logic [7:0]  dir_next [2];
    logic [7:0]  drv_next [2];
    logic [1:0]  rdy_next;
    logic [2:0]  def_next;
    logic [1:0]  pulse;
    logic [7:0]  rd;
    logic        fire;
    pio_pkg::pio_in_t p;

    assign p = in_ch.payload;
    assign in_ch.ready = !ovalid_reg || out_ch.ready;
    assign fire = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload = opay_reg;

    function automatic logic [7:0] drive_of(input logic [1:0] m, input logic [7:0] o,
                                            input logic [7:0] d);
        logic [7:0] r;
        r = o;
        if (m == pio_pkg::MODE_BIT)
            r = o & ~d;
        return r;
    endfunction

    always_comb
    begin
        logic       ch;
        logic [7:0] dat, pins [2], oldd, newd;
        logic       match, edg, rising;
        logic [3:0] lo;
        ch = p.port_select;
        dat = p.write_data;
        pins[0] = p.pins_a;
        pins[1] = p.pins_b;
        oldd = 8'h00;
        newd = 8'h00;
        match = 1'b0;
        edg = 1'b0;
        rising = 1'b0;
        lo = 4'h0;
        seq_next = seq_reg; mode_next = mode_reg; ien_next = ien_reg;
        pend_next = pend_reg; req_next = req_reg; svc_next = svc_reg;
        stb_next = stb_reg; match_next = match_reg; icw_next = icw_reg;
        inl_next = inl_reg; outl_next = outl_reg; vec_next = vec_reg;
        mask_next = mask_reg; dir_next = dir_reg; drv_next = drv_reg;
        rdy_next = rdy_reg; def_next = def_reg;
        pulse = 2'b00;
        rd = 8'h00;
        if (def_next[2])
        begin
            ien_next[def_next[1]] = def_next[0];
            def_next = 3'b000;
        end
        for (int c = 0; c < 2; c++)
        begin
            if (ien_next[c])
            begin
                if (pend_next[c])
                begin
                    req_next[c] = 1'b1;
                    pend_next[c] = 1'b0;
                end
            end
            else
                req_next[c] = 1'b0;
        end
        unique case (pio_pkg::action_t'(p.action))
            pio_pkg::ACT_WRITE:
            begin
                if (p.is_control)
                begin
                    lo = dat[3:0];
                    if (seq_reg[ch] == pio_pkg::SEQ_DIR || seq_reg[ch] == pio_pkg::SEQ_MASK)
                    begin
                        if (seq_reg[ch] == pio_pkg::SEQ_DIR)
                            dir_next[ch] = dat;
                        else
                            mask_next[ch] = dat;
                        if (icw_reg[ch][7])
                            def_next = {1'b1, ch, 1'b1};
                        else
                            ien_next[ch] = 1'b0;
                        seq_next[ch] = pio_pkg::SEQ_NORMAL;
                    end
                    else
                    begin
                        seq_next[ch] = pio_pkg::SEQ_NORMAL;
                        if (!dat[0])
                            vec_next[ch] = dat & 8'hfe;
                        else if (lo == pio_pkg::CW_ICTL_ONLY)
                        begin
                            icw_next[ch] = {dat[7], icw_reg[ch][6:0]};
                            if (dat[7])
                                def_next = {1'b1, ch, 1'b1};
                            else
                                ien_next[ch] = 1'b0;
                        end
                        else if (lo == pio_pkg::CW_MODE)
                        begin
                            unique case (pio_pkg::mode_t'(dat[7:6]))
                                pio_pkg::MODE_OUT:
                                begin
                                    mode_next[ch] = pio_pkg::MODE_OUT;
                                    drv_next[ch] = outl_reg[ch];
                                    rdy_next[ch] = 1'b1;
                                end
                                pio_pkg::MODE_IN: mode_next[ch] = pio_pkg::MODE_IN;
                                pio_pkg::MODE_BIDI:
                                begin
                                    if (!ch)
                                        mode_next[0] = pio_pkg::MODE_BIDI;
                                end
                                pio_pkg::MODE_BIT:
                                begin
                                    mode_next[ch] = pio_pkg::MODE_BIT;
                                    if (!ch || mode_reg[0] != pio_pkg::MODE_BIDI)
                                        rdy_next[ch] = 1'b0;
                                    ien_next[ch] = 1'b0;
                                    match_next[ch] = 1'b0;
                                    seq_next[ch] = pio_pkg::SEQ_DIR;
                                end
                            endcase
                        end
                        else if (lo == pio_pkg::CW_ICTL)
                        begin
                            icw_next[ch] = dat & 8'hf0;
                            if (dat[4])
                            begin
                                ien_next[ch] = 1'b0;
                                pend_next[ch] = 1'b0;
                                match_next[ch] = 1'b0;
                                seq_next[ch] = pio_pkg::SEQ_MASK;
                            end
                            else if (dat[7])
                                def_next = {1'b1, ch, 1'b1};
                            else
                                ien_next[ch] = 1'b0;
                        end
                    end
                end
                else
                begin
                    unique case (pio_pkg::mode_t'(mode_reg[ch]))
                        pio_pkg::MODE_OUT:
                        begin
                            outl_next[ch] = dat;
                            drv_next[ch] = dat;
                            rdy_next[ch] = 1'b1;
                            pulse[ch] = 1'b1;
                        end
                        pio_pkg::MODE_IN: ;
                        pio_pkg::MODE_BIDI:
                        begin
                            outl_next[ch] = dat;
                            if (!stb_reg[ch])
                                drv_next[ch] = dat;
                            rdy_next[ch] = 1'b1;
                            pulse[ch] = 1'b1;
                        end
                        pio_pkg::MODE_BIT:
                        begin
                            outl_next[ch] = dat;
                            drv_next[ch] = dat & ~dir_reg[ch];
                        end
                    endcase
                end
            end
            pio_pkg::ACT_READ:
            begin
                if (p.is_control)
                    rd = cfg_reg ? ((icw_reg[0] & 8'hc0) | {4'h0, icw_reg[1][7:4]}) : 8'h00;
                else
                begin
                    unique case (pio_pkg::mode_t'(mode_reg[ch]))
                        pio_pkg::MODE_OUT: rd = outl_reg[ch];
                        pio_pkg::MODE_IN:
                        begin
                            rd = inl_reg[ch];
                            rdy_next[ch] = 1'b1;
                            pulse[ch] = 1'b1;
                        end
                        pio_pkg::MODE_BIDI:
                        begin
                            rd = inl_reg[0] | (outl_reg[0] & ~dir_reg[0]);
                            rdy_next[1] = 1'b1;
                            pulse[1] = 1'b1;
                        end
                        pio_pkg::MODE_BIT:
                        begin
                            inl_next[ch] = pins[ch];
                            rd = (pins[ch] & dir_reg[ch]) | (outl_reg[ch] & ~dir_reg[ch]);
                        end
                    endcase
                end
            end
            pio_pkg::ACT_STB:
            begin
                rising = !stb_reg[ch] && p.strobe_level;
                if (mode_reg[0] == pio_pkg::MODE_BIDI)
                begin
                    if (!p.strobe_level)
                    begin
                        if (!ch)
                            drv_next[0] = drive_of(mode_reg[0], outl_reg[0], dir_reg[0]);
                        else
                            inl_next[0] = pins[0];
                    end
                    else if (rising)
                    begin
                        if (ien_next[ch]) req_next[ch] = 1'b1;
                        else pend_next[ch] = 1'b1;
                        rdy_next[ch] = 1'b0;
                    end
                end
                else if (mode_reg[ch] == pio_pkg::MODE_OUT)
                begin
                    if (rising)
                    begin
                        if (ien_next[ch]) req_next[ch] = 1'b1;
                        else pend_next[ch] = 1'b1;
                        rdy_next[ch] = 1'b0;
                    end
                end
                else if (mode_reg[ch] == pio_pkg::MODE_IN)
                begin
                    if (!p.strobe_level)
                        inl_next[ch] = pins[ch];
                    else if (rising)
                    begin
                        if (ien_next[ch]) req_next[ch] = 1'b1;
                        else pend_next[ch] = 1'b1;
                        rdy_next[ch] = 1'b0;
                    end
                end
                stb_next[ch] = p.strobe_level;
            end
            pio_pkg::ACT_POLL:
            begin
                for (int c = 0; c < 2; c++)
                begin
                    edg = icw_reg[c][5];
                    oldd = inl_reg[c] & dir_reg[c];
                    newd = pins[c] & dir_reg[c];
                    if (mode_reg[c] == pio_pkg::MODE_BIT && mask_reg[c] != 8'hff
                        && oldd != newd)
                    begin
                        match = 1'b0;
                        if (icw_reg[c][6])
                        begin
                            match = 1'b1;
                            for (int b = 0; b < 8; b++)
                                if (!mask_reg[c][b] && dir_reg[c][b]
                                    && !((oldd[b] ^ edg) && !(newd[b] ^ edg)))
                                    match = 1'b0;
                            if (&(mask_reg[c] | ~dir_reg[c]))
                                match = 1'b0;
                        end
                        else
                            for (int b = 0; b < 8; b++)
                                if (!mask_reg[c][b] && dir_reg[c][b]
                                    && (oldd[b] ^ edg) && !(newd[b] ^ edg))
                                    match = 1'b1;
                        if (!match_reg[c] && match)
                        begin
                            if (ien_next[c]) req_next[c] = 1'b1;
                            else pend_next[c] = 1'b1;
                            inl_next[c] = newd;
                        end
                        match_next[c] = match;
                    end
                end
            end
            pio_pkg::ACT_ACK:
            begin
                if (req_next[0])
                begin
                    req_next[0] = 1'b0;
                    svc_next[0] = 1'b1;
                    rd = vec_reg[0];
                end
                else if (req_next[1])
                begin
                    req_next[1] = 1'b0;
                    svc_next[1] = 1'b1;
                    rd = vec_reg[1];
                end
                else
                    rd = vec_reg[0];
            end
            pio_pkg::ACT_RETI:
            begin
                if (svc_next[0])
                    svc_next[0] = 1'b0;
                else if (svc_next[1])
                    svc_next[1] = 1'b0;
            end
            default: ;
        endcase
        for (int c = 0; c < 2; c++)
        begin
            if (ien_next[c])
            begin
                if (pend_next[c])
                begin
                    req_next[c] = 1'b1;
                    pend_next[c] = 1'b0;
                end
            end
            else
                req_next[c] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                seq_reg[c] <= pio_pkg::SEQ_NORMAL;
                mode_reg[c] <= pio_pkg::MODE_IN;
                icw_reg[c] <= 8'h00; inl_reg[c] <= 8'h00; outl_reg[c] <= 8'h00;
                vec_reg[c] <= 8'h00; mask_reg[c] <= 8'hff; dir_reg[c] <= 8'h00;
                drv_reg[c] <= 8'h00;
            end
            ien_reg <= '0; pend_reg <= '0; req_reg <= '0; svc_reg <= '0;
            stb_reg <= '0; match_reg <= '0; rdy_reg <= '0; def_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (fire)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (fire)
            begin
                seq_reg <= seq_next; mode_reg <= mode_next; icw_reg <= icw_next;
                inl_reg <= inl_next; outl_reg <= outl_next; vec_reg <= vec_next;
                mask_reg <= mask_next; dir_reg <= dir_next; drv_reg <= drv_next;
                ien_reg <= ien_next; pend_reg <= pend_next; req_reg <= req_next;
                svc_reg <= svc_next; stb_reg <= stb_next; match_reg <= match_next;
                rdy_reg <= rdy_next; def_reg <= def_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            opay_reg.read_data <= rd;
            opay_reg.port_a_drive <= drv_next[0];
            opay_reg.port_b_drive <= drv_next[1];
            opay_reg.ready_a <= rdy_next[0];
            opay_reg.ready_b <= rdy_next[1];
            opay_reg.ready_pulse <= pulse;
            opay_reg.int_line <= svc_next[0] ? 1'b0
                                 : (req_next[0] | (!svc_next[1] & req_next[1]));
        end
    end

endmodule
`default_nettype wire

/* hdl/pio_checker.sv */
// Checker: port-level assertions for the parallel I/O controller, with bind.
`default_nettype none
module pio_checker (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire logic [1:0] out_pulse,
    input wire logic      out_rdy_a,
    input wire logic      out_rdy_b
);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input stalled with empty output");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid) else $error("missing result");

    a_pulse_a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_pulse[0]) |-> out_rdy_a) else $error("pulse A without ready");

    a_pulse_b_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_pulse[1]) |-> out_rdy_b) else $error("pulse B without ready");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind parallel_io_controller pio_checker u_pio_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pulse (out_ch.payload.ready_pulse),
    .out_rdy_a (out_ch.payload.ready_a),
    .out_rdy_b (out_ch.payload.ready_b)
);
`default_nettype wire
